>>> rtl/fps_pkg.sv
// Shared constants and types of the frame packetizer.
`default_nettype none
package fps_pkg;
   localparam int FRAME_LEN_BITS = 12;
   localparam int DIV_CNT_BITS = $clog2(FRAME_LEN_BITS + 1);
   localparam int SEND_MAX = 182;
   localparam int HDR_BYTES = 2;
   localparam logic [7:0] PAYLOAD_MAX_RESET = 8'(SEND_MAX - HDR_BYTES);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] data;
      logic       hdr;
      logic [3:0] hdr0;
      logic [7:0] hdr1;
      logic       pend;
   } entry_type;
endpackage
`default_nettype wire

>>> rtl/fps_if.sv
// Request and response channel interfaces of the frame packetizer.
`default_nettype none
interface fps_req_if;
   logic                              valid;
   logic                              ready;
   logic [7:0]                        data_byte;
   logic [fps_pkg::FRAME_LEN_BITS-1:0] frame_length;
   modport source (output valid, output data_byte, output frame_length, input ready);
   modport sink (input valid, input data_byte, input frame_length, output ready);
endinterface

interface fps_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_header;
   logic       packet_end;
   logic       last_of_item;
   modport source (output valid, output out_byte, output is_header, output packet_end,
                   output last_of_item, input ready);
   modport sink (input valid, input out_byte, input is_header, input packet_end,
                 input last_of_item, output ready);
endinterface
`default_nettype wire

>>> rtl/frame_packetizer_seq_header.sv
// Frame packetizer top level: CSR, front end, queue and byte emitter.
// A continuing byte is written into the queue and registered in the emitter before it
// reaches the response port. A frame-start request first runs the restoring divider
// (one quotient bit per cycle) that yields the packet count. Throughput: one request
// per cycle into the queue while the front end is in its run state and the queue is
// not full; the emitter sends 3 bytes for a packet-opening request and 1 byte otherwise.
// Reset clears all sequence state, empties the queue and sets payload_max to 180.
`default_nettype none
module frame_packetizer_seq_header (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_we,
   input  wire logic [7:0] csr_wdata,
   fps_req_if.sink         req_ch,
   fps_rsp_if.source       rsp_ch
);
   logic [7:0]          pmax_ff, pmax_in;
   logic                q_full;
   logic                q_push;
   logic                q_valid;
   logic                q_pop;
   fps_pkg::entry_type  push_entry;
   fps_pkg::entry_type  pop_entry;

   assign pmax_in = csr_we ? csr_wdata : pmax_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pmax_ff <= fps_pkg::PAYLOAD_MAX_RESET;
      end else begin
         pmax_ff <= pmax_in;
      end
   end

   fps_front u_front (
      .clock   (clock),
      .reset   (reset),
      .pmax    (pmax_ff),
      .req     (req_ch),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (push_entry)
   );

   fps_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (push_entry),
      .full  (q_full),
      .pop   (q_pop),
      .valid (q_valid),
      .dout  (pop_entry)
   );

   fps_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_entry (pop_entry),
      .q_pop   (q_pop),
      .rsp     (rsp_ch)
   );
endmodule
`default_nettype wire

>>> rtl/fps_front.sv
// Front end: request intake, packet-count divider and packet sequencing state.
`default_nettype none
module fps_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [7:0]          pmax,
   fps_req_if.sink                  req,
   input  wire logic                q_full,
   output logic                     q_push,
   output fps_pkg::entry_type       q_entry
);
   localparam int FLB = fps_pkg::FRAME_LEN_BITS;
   localparam int CNB = fps_pkg::DIV_CNT_BITS;
   localparam logic [1:0] ST_RUN  = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_PUSH = 2'd2;

   logic [1:0]     state_ff, state_in;
   logic [7:0]     data_ff, data_in;
   logic [FLB-1:0] len_ff, len_in;
   logic [FLB-1:0] dvd_ff, dvd_in;
   logic [7:0]     rem_ff, rem_in;
   logic [CNB-1:0] cnt_ff, cnt_in;
   logic [FLB-1:0] frame_left_ff, frame_left_in;
   logic [7:0]     pkt_left_ff, pkt_left_in;
   logic [3:0]     pseq_ff, pseq_in;
   logic [3:0]     tot_ff, tot_in;
   logic [3:0]     fseq_ff, fseq_in;

   logic           accept;
   logic [7:0]     pmax_eff;
   logic [8:0]     rem_shift;
   logic [8:0]     rem_sub;
   logic           rem_ge;
   logic [3:0]     nib;
   logic           start;
   logic [FLB-1:0] flen;
   logic [7:0]     pleft;
   logic [3:0]     pseq;
   logic [3:0]     tot;
   logic           hdr;
   logic [7:0]     cap;
   logic [7:0]     pl;
   logic [7:0]     pl_dec;
   logic [FLB-1:0] fl_dec;
   logic           pend;

   assign req.ready = (state_ff == ST_RUN) && !q_full;
   assign accept    = req.valid && req.ready;
   assign pmax_eff  = (pmax == 8'd0) ? 8'd1 : pmax;

   assign rem_shift = {rem_ff, dvd_ff[FLB-1]};
   assign rem_ge    = rem_shift >= {1'b0, pmax_eff};
   assign rem_sub   = rem_shift - {1'b0, pmax_eff};
   assign nib       = dvd_ff[3:0] + {3'd0, (rem_ff != 8'd0)};

   always_comb begin
      start  = (state_ff == ST_PUSH);
      flen   = start ? len_ff : frame_left_ff;
      pleft  = start ? 8'd0 : pkt_left_ff;
      pseq   = start ? 4'd0 : pseq_ff;
      tot    = start ? nib : tot_ff;
      hdr    = (pleft == 8'd0);
      cap    = (flen < FLB'(pmax_eff)) ? flen[7:0] : pmax_eff;
      pl     = hdr ? cap : pleft;
      pl_dec = pl - 8'd1;
      fl_dec = flen - FLB'(1);
      pend   = (pl_dec == 8'd0);
      q_entry.data = start ? data_ff : req.data_byte;
      q_entry.hdr  = hdr;
      q_entry.hdr0 = fseq_ff;
      q_entry.hdr1 = {tot, pseq};
      q_entry.pend = pend;
   end

   always_comb begin
      state_in      = state_ff;
      data_in       = data_ff;
      len_in        = len_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      frame_left_in = frame_left_ff;
      pkt_left_in   = pkt_left_ff;
      pseq_in       = pseq_ff;
      tot_in        = tot_ff;
      fseq_in       = fseq_ff;
      q_push        = 1'b0;
      case (state_ff)
         ST_RUN: begin
            if (accept) begin
               if (frame_left_ff == '0) begin
                  if (req.frame_length != '0) begin
                     data_in  = req.data_byte;
                     len_in   = req.frame_length;
                     dvd_in   = req.frame_length;
                     rem_in   = 8'd0;
                     cnt_in   = CNB'(FLB);
                     state_in = ST_DIV;
                  end
               end else begin
                  q_push = 1'b1;
               end
            end
         end
         ST_DIV: begin
            dvd_in = {dvd_ff[FLB-2:0], rem_ge};
            rem_in = rem_ge ? rem_sub[7:0] : rem_shift[7:0];
            cnt_in = cnt_ff - CNB'(1);
            if (cnt_ff == CNB'(1)) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
      if (q_push) begin
         pkt_left_in   = pl_dec;
         frame_left_in = fl_dec;
         tot_in        = tot;
         pseq_in       = pend ? pseq + 4'd1 : pseq;
         if (fl_dec == '0) begin
            fseq_in     = fseq_ff + 4'd1;
            pseq_in     = 4'd0;
            pkt_left_in = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         cnt_ff        <= '0;
         frame_left_ff <= '0;
         pkt_left_ff   <= 8'd0;
         pseq_ff       <= 4'd0;
         tot_ff        <= 4'd0;
         fseq_ff       <= 4'd0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         frame_left_ff <= frame_left_in;
         pkt_left_ff   <= pkt_left_in;
         pseq_ff       <= pseq_in;
         tot_ff        <= tot_in;
         fseq_ff       <= fseq_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      len_ff  <= len_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
   end

   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_RUN) |-> !req.ready)
      else $error("request taken while divider busy");
   a_div_to_push: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff == CNB'(1)) |=> (state_ff == ST_PUSH))
      else $error("divider did not finish on its last step");
endmodule
`default_nettype wire

>>> rtl/fps_queue.sv
// Two-entry queue between the front end and the byte emitter.
`default_nettype none
module fps_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire fps_pkg::entry_type  din,
   output logic                     full,
   input  wire logic                pop,
   output logic                     valid,
   output fps_pkg::entry_type       dout
);
   localparam int PTB = fps_pkg::QUEUE_PTR_BITS;
   localparam int CTB = fps_pkg::QUEUE_CNT_BITS;

   fps_pkg::entry_type mem_ff [fps_pkg::QUEUE_DEPTH];
   logic [PTB-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTB-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CTB-1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == CTB'(fps_pkg::QUEUE_DEPTH));
   assign valid = (cnt_ff != '0);
   assign dout  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTB'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTB'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + CTB'(push) - CTB'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> valid)
      else $error("queue underflow");
endmodule
`default_nettype wire

>>> rtl/fps_back.sv
// Back end: expands queued entries into header and payload bytes.
`default_nettype none
module fps_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  wire fps_pkg::entry_type  q_entry,
   output logic                     q_pop,
   fps_rsp_if.source                rsp
);
   localparam logic [1:0] PH_HDR0 = 2'd0;
   localparam logic [1:0] PH_HDR1 = 2'd1;
   localparam logic [1:0] PH_DATA = 2'd2;

   fps_pkg::entry_type cur_ff, cur_in;
   logic       vld_ff, vld_in;
   logic [1:0] ph_ff, ph_in;
   logic       fire;
   logic       done;

   assign rsp.valid = vld_ff;
   assign fire      = vld_ff && rsp.ready;
   assign done      = fire && (ph_ff == PH_DATA);
   assign q_pop     = q_valid && (!vld_ff || done);

   always_comb begin
      cur_in = cur_ff;
      vld_in = vld_ff;
      ph_in  = ph_ff;
      if (q_pop) begin
         cur_in = q_entry;
         vld_in = 1'b1;
         ph_in  = q_entry.hdr ? PH_HDR0 : PH_DATA;
      end else if (done) begin
         vld_in = 1'b0;
      end else if (fire) begin
         ph_in = ph_ff + 2'd1;
      end
   end

   always_comb begin
      case (ph_ff)
         PH_HDR0: begin
            rsp.out_byte     = {4'd0, cur_ff.hdr0};
            rsp.is_header    = 1'b1;
            rsp.packet_end   = 1'b0;
            rsp.last_of_item = 1'b0;
         end
         PH_HDR1: begin
            rsp.out_byte     = cur_ff.hdr1;
            rsp.is_header    = 1'b1;
            rsp.packet_end   = 1'b0;
            rsp.last_of_item = 1'b0;
         end
         PH_DATA: begin
            rsp.out_byte     = cur_ff.data;
            rsp.is_header    = 1'b0;
            rsp.packet_end   = cur_ff.pend;
            rsp.last_of_item = 1'b1;
         end
         default: begin
            rsp.out_byte     = 8'd0;
            rsp.is_header    = 1'b0;
            rsp.packet_end   = 1'b0;
            rsp.last_of_item = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         ph_ff  <= PH_DATA;
      end else begin
         vld_ff <= vld_in;
         ph_ff  <= ph_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   a_hdr_order: assert property (@(posedge clock) disable iff (reset)
      (fire && ph_ff == PH_HDR0) |=> (vld_ff && ph_ff == PH_HDR1))
      else $error("second header byte did not follow the first");
   a_hdr_then_data: assert property (@(posedge clock) disable iff (reset)
      (fire && ph_ff == PH_HDR1) |=> (vld_ff && ph_ff == PH_DATA))
      else $error("payload byte did not follow the header");
endmodule
`default_nettype wire
